// File: rtl/cce_pkg.sv
// Shared types, character constants and the run encoder function of the escaper.
// No dependencies; used by every module of the control_char_escaper block.
`timescale 1ns / 1ps

package cce_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RunLen  = 4;
  localparam int unsigned RunIdxW = $clog2(RunLen);

  localparam logic [ByteW-1:0] CtrlLimit     = 8'h20;
  localparam logic [ByteW-1:0] DelFirst      = 8'h7f;
  localparam logic [ByteW-1:0] C1Limit       = 8'ha0;
  localparam logic [ByteW-1:0] CharBackslash = 8'h5c;
  localparam logic [ByteW-1:0] CharX         = 8'h78;
  localparam logic [ByteW-1:0] CharZero      = 8'h30;
  localparam logic [ByteW-1:0] HexAlphaBase  = 8'h57;

  localparam logic [ByteW-1:0] CodeNul = 8'h00;
  localparam logic [ByteW-1:0] CodeBs  = 8'h08;
  localparam logic [ByteW-1:0] CodeLf  = 8'h0a;
  localparam logic [ByteW-1:0] CodeVt  = 8'h0b;
  localparam logic [ByteW-1:0] CodeFf  = 8'h0c;
  localparam logic [ByteW-1:0] CodeCr  = 8'h0d;

  localparam logic [ByteW-1:0] LetterN = 8'h6e;
  localparam logic [ByteW-1:0] LetterR = 8'h72;
  localparam logic [ByteW-1:0] LetterF = 8'h66;
  localparam logic [ByteW-1:0] LetterV = 8'h76;
  localparam logic [ByteW-1:0] LetterB = 8'h62;

  localparam logic [RunIdxW-1:0] LastOfPlain = 2'd0;
  localparam logic [RunIdxW-1:0] LastOfShort = 2'd1;
  localparam logic [RunIdxW-1:0] LastOfHex   = 2'd3;

  typedef enum logic {
    CfgFirstDelim  = 1'b0,
    CfgSecondDelim = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [RunLen-1:0][ByteW-1:0] chars;
    logic [RunIdxW-1:0]           last_idx;
    logic                         fin;
  } run_t;

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    logic [ByteW-1:0] wide;
    wide = {4'h0, nib};
    hex_char = (nib < 4'd10) ? (CharZero + wide) : (HexAlphaBase + wide);
  endfunction

  function automatic run_t encode_run(input logic [ByteW-1:0] b, input logic fin,
                                      input logic [ByteW-1:0] d1,
                                      input logic [ByteW-1:0] d2);
    run_t             r;
    logic             esc;
    logic [ByteW-1:0] letter;
    esc = (b < CtrlLimit) || ((b >= DelFirst) && (b < C1Limit)) || (b == d1) || (b == d2)
          || (((d1 != '0) || (d2 != '0)) && (b == CharBackslash));
    case (b)
      CodeLf:  letter = LetterN;
      CodeCr:  letter = LetterR;
      CodeFf:  letter = LetterF;
      CodeVt:  letter = LetterV;
      CodeBs:  letter = LetterB;
      CodeNul: letter = CharZero;
      default: letter = '0;
    endcase
    r.fin = fin;
    if (!esc) begin
      r.chars    = {CharX, CharX, CharX, b};
      r.last_idx = LastOfPlain;
    end else if (letter != '0) begin
      r.chars    = {CharX, CharX, letter, CharBackslash};
      r.last_idx = LastOfShort;
    end else begin
      r.chars    = {hex_char(b[3:0]), hex_char(b[7:4]), CharX, CharBackslash};
      r.last_idx = LastOfHex;
    end
    encode_run = r;
  endfunction

endpackage

// File: rtl/cce_encoder.sv
// Run register of the escaper: encodes an accepted byte into its run of characters.
// Depends on cce_pkg.
`timescale 1ns / 1ps

module cce_encoder (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [cce_pkg::ByteW-1:0] first_delim_i,
  input  logic [cce_pkg::ByteW-1:0] second_delim_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [cce_pkg::ByteW-1:0] in_byte_i,
  input  logic                     in_final_i,
  input  logic                     run_done_i,
  output logic                     run_valid_o,
  output cce_pkg::run_t            run_o
);
  import cce_pkg::*;

  logic run_valid_q, run_valid_d;
  run_t run_q, run_d;
  logic accept;

  assign in_stall_o = run_valid_q && !run_done_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    run_valid_d = run_valid_q;
    run_d       = run_q;
    if (accept) begin
      run_valid_d = 1'b1;
      run_d       = encode_run(in_byte_i, in_final_i, first_delim_i, second_delim_i);
    end else if (run_done_i) begin
      run_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
    end else begin
      run_valid_q <= run_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

  assign run_valid_o = run_valid_q;
  assign run_o       = run_q;

endmodule

// File: rtl/cce_serializer.sv
// Output stage of the escaper: steps through a run and holds one character a request.
// Depends on cce_pkg.
`timescale 1ns / 1ps

module cce_serializer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      run_valid_i,
  input  cce_pkg::run_t             run_i,
  output logic                      run_done_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cce_pkg::ByteW-1:0] out_char_o,
  output logic                      run_last_o,
  output logic                      string_last_o
);
  import cce_pkg::*;

  logic [RunIdxW-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   char_q, char_d;
  logic               run_last_q, run_last_d;
  logic               str_last_q, str_last_d;
  logic               load, at_last;

  assign load       = run_valid_i && (!out_valid_q || !out_stall_i);
  assign at_last    = (idx_q == run_i.last_idx);
  assign run_done_o = load && at_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    run_last_d  = run_last_q;
    str_last_d  = str_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      char_d      = run_i.chars[idx_q];
      run_last_d  = at_last;
      str_last_d  = at_last && run_i.fin;
      idx_d       = at_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    run_last_q <= run_last_d;
    str_last_q <= str_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = char_q;
  assign run_last_o    = run_last_q;
  assign string_last_o = str_last_q;

endmodule

// File: rtl/control_char_escaper.sv
// Control character escaper: turns each raw input byte into a run of one, two or four
// printable characters. The byte is encoded into a run register in the cycle it is
// accepted, and the output register then emits one character a cycle while out_stall_i
// is low. A new byte is accepted in the cycle the last character of the previous run
// moves into the output register.
`timescale 1ns / 1ps

module control_char_escaper (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [cce_pkg::ByteW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [cce_pkg::ByteW-1:0] in_byte_i,
  input  logic                      in_final_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cce_pkg::ByteW-1:0] out_char_o,
  output logic                      run_last_o,
  output logic                      string_last_o
);
  import cce_pkg::*;

  logic [ByteW-1:0] first_delim_q, second_delim_q;
  logic             run_valid, run_done;
  run_t             run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delim_q  <= '0;
      second_delim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFirstDelim:  first_delim_q  <= cfg_data_i;
        CfgSecondDelim: second_delim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cce_encoder u_encoder (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .first_delim_i  (first_delim_q),
    .second_delim_i (second_delim_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .in_final_i     (in_final_i),
    .run_done_i     (run_done),
    .run_valid_o    (run_valid),
    .run_o          (run)
  );

  cce_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .run_valid_i   (run_valid),
    .run_i         (run),
    .run_done_o    (run_done),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

`ifndef SYNTHESIS
  a_str_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_last_o |-> run_last_o)
    else $error("string end flagged on a character that does not end its run");

  a_done_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done |-> run_valid)
    else $error("run completed while no run was held");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("run broken off before its last character");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid && !run_done |-> in_stall_o)
    else $error("new request accepted over an unfinished run");
`endif

endmodule
